// ===== rtl/swsu_pkg.sv =====
// Shared definitions for the sliding sorted window block.
// Holds sizes, the window entry layout and the sequencer state codes.
// No dependencies.
package swsu_pkg;

   localparam int WINDOW      = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int AGE_BITS    = 7;

   // Position inside one window bank, and a count that can also hold WINDOW
   localparam int IDX_BITS      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_BITS      = $clog2(WINDOW + 1);
   // Two banks: one is read while the merged window is written to the other
   localparam int RAM_ADDR_BITS = IDX_BITS + 1;
   localparam int RAM_DEPTH     = 2 ** RAM_ADDR_BITS;
   localparam int ENTRY_BITS    = SAMPLE_BITS + AGE_BITS;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [AGE_BITS-1:0]           age_type;
   typedef logic [IDX_BITS-1:0]           idx_type;
   typedef logic [CNT_BITS-1:0]           cnt_type;
   typedef logic [RAM_ADDR_BITS-1:0]      ram_addr_type;

   typedef struct packed {
      sample_type value;
      age_type    age;
   } entry_type;

   localparam age_type AGE_NEWEST = age_type'(WINDOW);
   localparam age_type AGE_OLDEST = age_type'(1);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_RUN   = 3'b100
   } state_type;

endpackage

// ===== rtl/swsu_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Self-contained; no package dependency.
module swsu_ram #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 16
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_BITS-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_BITS-1:0]         rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sliding_window_sorted_update.sv =====
// Sliding sorted window: sequencer, merge logic and result register.
// Depends on swsu_pkg and instantiates swsu_ram.
//
// The block keeps WINDOW samples in ascending order, each tagged with an age
// (WINDOW newest, 1 oldest). Each accepted sample retires the entry of age 1,
// ages the rest by one, is inserted ahead of the first kept entry not smaller
// than it, and the whole new window is then returned as WINDOW result
// transactions in ascending order, rsp_last marking the final one. The window
// lives in one RAM split into two banks: the current window is streamed out of
// one bank, one entry per cycle unless results are stalled, while the merged
// window is written to the other, and the banks swap at the end of each run.
// One result leaves per cycle unless results are stalled, apart from the accept
// step and the skip over the retired entry. After reset a clearing pass loads
// the initial window; no sample is taken during it.
module sliding_window_sorted_update (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  swsu_pkg::sample_type  req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output swsu_pkg::sample_type  rsp_sorted_value,
   output swsu_pkg::age_type     rsp_entry_age,
   output logic                  rsp_last
);
   import swsu_pkg::*;

   state_type    state_ff, state_in;
   logic         bank_ff, bank_in;
   cnt_type      rd_idx_ff, rd_idx_in;
   idx_type      n_ff, n_in;
   logic         placed_ff, placed_in;
   sample_type   sample_ff, sample_in;

   logic         rsp_valid_ff, rsp_valid_in;
   sample_type   rsp_value_ff, rsp_value_in;
   age_type      rsp_age_ff, rsp_age_in;
   logic         rsp_last_ff, rsp_last_in;

   logic         wr_en;
   ram_addr_type wr_addr;
   entry_type    wr_entry;
   ram_addr_type rd_addr;
   idx_type      rd_pos;
   logic [ENTRY_BITS-1:0] rd_data;
   entry_type    rd_entry;

   logic         out_free;
   logic         ent_vld;
   logic         emit;
   entry_type    emit_entry;
   logic         emit_last;

   // Window storage, two banks
   swsu_ram #(
      .DATA_BITS (ENTRY_BITS),
      .DEPTH     (RAM_DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry = entry_type'(rd_data);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ent_vld  = (rd_idx_ff != cnt_type'(WINDOW));

   // Sequencer and merge step
   always_comb begin
      state_in   = state_ff;
      bank_in    = bank_ff;
      rd_idx_in  = rd_idx_ff;
      n_in       = n_ff;
      placed_in  = placed_ff;
      sample_in  = sample_ff;
      wr_en      = 1'b0;
      wr_addr    = {bank_ff, n_ff};
      wr_entry   = '{value: '0, age: age_type'(n_ff) + AGE_OLDEST};
      emit       = 1'b0;
      emit_entry = '{value: sample_ff, age: AGE_NEWEST};
      emit_last  = 1'b0;
      req_stall  = 1'b1;

      case (state_ff)
         ST_CLEAR: begin
            // load the reset window into bank zero
            wr_en   = 1'b1;
            wr_addr = {1'b0, n_ff};
            if (n_ff == idx_type'(WINDOW - 1)) begin
               n_in     = '0;
               state_in = ST_IDLE;
            end else begin
               n_in = n_ff + idx_type'(1);
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               sample_in = req_sample;
               placed_in = 1'b0;
               rd_idx_in = '0;
               n_in      = '0;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            if (ent_vld && rd_entry.age == AGE_OLDEST) begin
               // drop the retired entry
               rd_idx_in = rd_idx_ff + cnt_type'(1);
            end else if (out_free) begin
               emit = 1'b1;
               if (ent_vld && !placed_ff && rd_entry.value >= sample_ff) begin
                  // insert the new sample ahead of this entry, hold the entry
                  placed_in = 1'b1;
               end else if (ent_vld) begin
                  // pass the entry on, one step older
                  emit_entry = '{value: rd_entry.value,
                                 age:   rd_entry.age - AGE_OLDEST};
                  rd_idx_in  = rd_idx_ff + cnt_type'(1);
               end
               wr_en    = 1'b1;
               wr_addr  = {!bank_ff, n_ff};
               wr_entry = emit_entry;
               if (n_ff == idx_type'(WINDOW - 1)) begin
                  emit_last = 1'b1;
                  n_in      = '0;
                  bank_in   = !bank_ff;
                  state_in  = ST_IDLE;
               end else begin
                  n_in = n_ff + idx_type'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Read address follows the next entry index so data lines up next cycle
   assign rd_pos  = (rd_idx_in == cnt_type'(WINDOW)) ? '0 : rd_idx_in[IDX_BITS-1:0];
   assign rd_addr = {bank_ff, rd_pos};

   // Result register: load on emit, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_age_in   = rsp_age_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = emit_entry.value;
         rsp_age_in   = emit_entry.age;
         rsp_last_in  = emit_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         bank_ff      <= 1'b0;
         rd_idx_ff    <= '0;
         n_ff         <= '0;
         placed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         rd_idx_ff    <= rd_idx_in;
         n_ff         <= n_in;
         placed_ff    <= placed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      rsp_value_ff <= rsp_value_in;
      rsp_age_ff   <= rsp_age_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_entry_age    = rsp_age_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== tb/swsu_window_checker.sv =====
// Scoreboard for the sliding sorted window: watches both channels, predicts each run.
// Depends on swsu_pkg for the window size, the sample and age types and the age limits.
// Reports the mismatch count and the number of window entries still awaited.
module swsu_window_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  swsu_pkg::sample_type req_sample,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  swsu_pkg::sample_type rsp_sorted_value,
   input  swsu_pkg::age_type    rsp_entry_age,
   input  logic                 rsp_last,
   output int                   error_count,
   output int                   pending,
   output int                   samples_seen,
   output int                   entries_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import swsu_pkg::*;

   typedef struct {
      sample_type value;
      age_type    age;
      logic       last;
   } window_slot_type;

   // Predicted window contents, kept in ascending order
   sample_type      held_value [WINDOW];
   age_type         held_age   [WINDOW];
   window_slot_type expected_entries [$];

   int mismatches = 0;
   int samples    = 0;
   int entries    = 0;

   assign error_count  = mismatches;
   assign pending      = expected_entries.size();
   assign samples_seen = samples;
   assign entries_seen = entries;

   // Retire the oldest entry, age the rest, insert the new sample ahead of
   // equal values and queue the whole new window as expected results
   task automatic slide_window(input sample_type s);
      sample_type      next_value [WINDOW];
      age_type         next_age   [WINDOW];
      window_slot_type slot;
      int              n;
      bit              placed;
      n      = 0;
      placed = 1'b0;
      for (int i = 0; i < WINDOW && n < WINDOW; i++) begin
         if (held_age[i] == AGE_OLDEST)
            continue;
         if (!placed && held_value[i] >= s) begin
            next_value[n] = s;
            next_age[n]   = AGE_NEWEST;
            n++;
            placed = 1'b1;
            if (n >= WINDOW)
               break;
         end
         next_value[n] = held_value[i];
         next_age[n]   = held_age[i] - age_type'(1);
         n++;
      end
      // Largest sample so far, or any slot left free: fill with the new sample
      while (n < WINDOW) begin
         next_value[n] = s;
         next_age[n]   = AGE_NEWEST;
         n++;
      end
      for (int i = 0; i < WINDOW; i++) begin
         held_value[i] = next_value[i];
         held_age[i]   = next_age[i];
         slot.value    = next_value[i];
         slot.age      = next_age[i];
         slot.last     = (i == WINDOW - 1);
         expected_entries.push_back(slot);
      end
   endtask

   always @(posedge clock) begin
      window_slot_type want;
      if (reset) begin
         // Hold the reset window: zero values, ages ascending by position
         for (int i = 0; i < WINDOW; i++) begin
            held_value[i] = '0;
            held_age[i]   = age_type'(i + 1);
         end
         expected_entries.delete();
      end else begin
         // Compare each accepted result transaction with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            entries++;
            if (expected_entries.size() == 0) begin
               $error("unexpected result transaction: value %0d age %0d last %0b",
                      rsp_sorted_value, rsp_entry_age, rsp_last);
               mismatches++;
            end else begin
               want = expected_entries.pop_front();
               if (rsp_sorted_value !== want.value) begin
                  $error("sorted_value: expected %0d, got %0d", want.value, rsp_sorted_value);
                  mismatches++;
               end
               if (rsp_entry_age !== want.age) begin
                  $error("entry_age: expected %0d, got %0d", want.age, rsp_entry_age);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  mismatches++;
               end
            end
         end
         // Predict the run caused by each accepted sample transaction
         if (req_valid && !req_stall) begin
            samples++;
            slide_window(req_sample);
         end
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the sliding sorted window testbench: clock, reset, stimulus and verdict.
// Depends on swsu_pkg, the block sliding_window_sorted_update and swsu_window_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import swsu_pkg::*;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_valid  = 1'b0;
   logic       req_stall;
   sample_type req_sample = '0;
   logic       rsp_valid;
   logic       rsp_stall  = 1'b0;
   sample_type rsp_sorted_value;
   age_type    rsp_entry_age;
   logic       rsp_last;

   int error_count;
   int pending;
   int samples_seen;
   int entries_seen;

   int send_idle_pct = 31;
   int stall_pct     = 50;

   sliding_window_sorted_update DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_entry_age    (rsp_entry_age),
      .rsp_last         (rsp_last)
   );

   swsu_window_checker window_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_entry_age    (rsp_entry_age),
      .rsp_last         (rsp_last),
      .error_count      (error_count),
      .pending          (pending),
      .samples_seen     (samples_seen),
      .entries_seen     (entries_seen)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Back-pressure on the result channel at the current stall rate
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Offer one sample transaction, idling at random first; hold it until accepted
   task automatic send_sample(input sample_type s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
   endtask

   // Mix of full-range values, narrow values that force ties, extremes and small steps
   function automatic sample_type pick_sample(input sample_type prev);
      int kind;
      int v;
      kind = $urandom_range(0, 99);
      if (kind < 40)
         return sample_type'($urandom);
      if (kind < 70) begin
         v = $urandom_range(0, 6);
         return sample_type'(v - 3);
      end
      if (kind < 80)
         return $urandom_range(0, 1) ? sample_type'(32767) : sample_type'(-32768);
      v = $urandom_range(0, 20);
      return prev + sample_type'(v - 10);
   endfunction

   initial begin
      sample_type directed [$];
      sample_type prev;
      directed = '{0, 0, 32767, -32768, -1, 1, 32767, -32768, 0, -1,
                   100, 200, 300, 400, 500, 500, 400, 300, 200, 100,
                   -32767, 32766, 7, 7, 7};
      prev = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: ties with the reset window, extremes, runs up and down
      foreach (directed[i])
         send_sample(directed[i]);

      // Random, sender idling less than the receiver stalls
      repeat (42) begin
         prev = pick_sample(prev);
         send_sample(prev);
      end

      // Random, swap the idle rates
      send_idle_pct = 50;
      stall_pct     = 31;
      repeat (42) begin
         prev = pick_sample(prev);
         send_sample(prev);
      end

      // Random, both sides at full rate
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (42) begin
         prev = pick_sample(prev);
         send_sample(prev);
      end
      req_valid <= 1'b0;

      // Drain every awaited entry, then watch for strays
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (WINDOW + 4) @(posedge clock);

      if (pending != 0)
         $error("%0d window entries never arrived", pending);
      $display("Run covered %0d samples and %0d window entries checked,", samples_seen,
               entries_seen);
      $display("with ties, extremes, narrow and full-range values under mixed idling.");
      if (error_count == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog well beyond the slowest correct run
   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
